/* hw/rtl/srarq_pkg.sv */
// ----------------------------------------------------------------------------
// srarq_pkg
// Shared types and constants of the selective-repeat ARQ controller: item
// layouts, event, frame kind and action codes, and the controller/datapath
// command and status bundles.
// ----------------------------------------------------------------------------
package srarq_pkg;

    // Field widths, fixed by the link format.
    localparam int SEQ_W   = 4;
    localparam int SLOT_W  = 3;
    localparam int TIMER_W = 16;
    localparam int OP_W    = 3;
    localparam int KIND_W  = 2;
    localparam int ACT_W   = 3;

    // Window geometry and result limit.
    localparam int MAX_SEQUENCE = 15;
    localparam int WINDOW_SLOTS = 8;
    localparam int MAX_RESULTS  = 12;

    // Configuration register indexes and reset values.
    localparam int          CFG_IDX_W       = 1;
    localparam logic [0:0]  CFG_DATA_TIMER  = 1'b0;
    localparam logic [0:0]  CFG_ACK_TIMER   = 1'b1;
    localparam logic [15:0] DATA_TIMER_INIT = 16'd4000;
    localparam logic [15:0] ACK_TIMER_INIT  = 16'd1000;

    // Event codes.
    localparam logic [OP_W-1:0] OP_NET_READY  = 3'd0;
    localparam logic [OP_W-1:0] OP_PHYS_READY = 3'd1;
    localparam logic [OP_W-1:0] OP_FRAME      = 3'd2;
    localparam logic [OP_W-1:0] OP_DATA_TMO   = 3'd3;
    localparam logic [OP_W-1:0] OP_ACK_TMO    = 3'd4;

    // Received frame kinds.
    localparam logic [KIND_W-1:0] KIND_DATA = 2'd0;
    localparam logic [KIND_W-1:0] KIND_ACK  = 2'd1;
    localparam logic [KIND_W-1:0] KIND_NAK  = 2'd2;

    // Result actions.
    localparam logic [ACT_W-1:0] ACT_LOAD    = 3'd0;
    localparam logic [ACT_W-1:0] ACT_DATA    = 3'd1;
    localparam logic [ACT_W-1:0] ACT_ACK     = 3'd2;
    localparam logic [ACT_W-1:0] ACT_NAK     = 3'd3;
    localparam logic [ACT_W-1:0] ACT_STORE   = 3'd4;
    localparam logic [ACT_W-1:0] ACT_DELIVER = 3'd5;
    localparam logic [ACT_W-1:0] ACT_STOP    = 3'd6;
    localparam logic [ACT_W-1:0] ACT_STATUS  = 3'd7;

    // One input event item.
    typedef struct packed {
        logic [OP_W-1:0]   op;
        logic              crc_bad;
        logic [KIND_W-1:0] rx_kind;
        logic [SEQ_W-1:0]  rx_seq;
        logic [SEQ_W-1:0]  rx_ack;
        logic [SLOT_W-1:0] timeout_slot;
    } t_item;

    // One result command item.
    typedef struct packed {
        logic [ACT_W-1:0]   action;
        logic [SEQ_W-1:0]   tx_seq;
        logic [SEQ_W-1:0]   tx_ack;
        logic [SLOT_W-1:0]  slot;
        logic [TIMER_W-1:0] timer_length;
        logic               ack_restart;
        logic               network_enable;
        logic               last;
    } t_result;

    // Datapath steps issued by the controller, at most one per cycle.
    typedef enum logic [3:0] {
        STEP_NONE,
        STEP_LOAD,
        STEP_SEND,
        STEP_NAK,
        STEP_ACK_START,
        STEP_STORE,
        STEP_DELIVER,
        STEP_STOP,
        STEP_SEND_ACK,
        STEP_PHYS,
        STEP_STATUS
    } t_step;

    // Controller to datapath.
    typedef struct packed {
        logic  latch;
        t_step step;
    } t_dp_cmd;

    // Datapath to controller.
    typedef struct packed {
        logic [OP_W-1:0]   op;
        logic              crc_bad;
        logic [KIND_W-1:0] rx_kind;
        logic              room;
        logic              nak_allowed;
        logic              seq_mismatch;
        logic              store_ok;
        logic              deliver_ok;
        logic              stop_ok;
        logic              resend_ok;
    } t_dp_stat;

endpackage

/* hw/rtl/srarq_dp.sv */
// ----------------------------------------------------------------------------
// srarq_dp
// Datapath of the ARQ controller: window edges, arrival marks, outstanding
// count, flags, timer length registers and the registered result port.
// ----------------------------------------------------------------------------
module srarq_dp import srarq_pkg::*; (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  t_item                i_item,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [TIMER_W-1:0]   i_cfg_data,
    input  t_dp_cmd              i_cmd,
    output t_dp_stat             o_stat,
    output logic                 o_strobe,
    output t_result              o_result
);

    localparam int GUARD_W = $clog2(MAX_SEQUENCE + 2);
    localparam int EMIT_W  = $clog2(MAX_RESULTS);

    // True when b lies in the circular range starting at a and ending before c.
    function automatic logic in_window(input logic [SEQ_W-1:0] a,
                                       input logic [SEQ_W-1:0] b,
                                       input logic [SEQ_W-1:0] c);
        in_window = ((a <= b) && (b < c)) || ((c < a) && (a <= b)) ||
                    ((c < a) && (b < c));
    endfunction

    t_item               r_item;
    logic [TIMER_W-1:0]  r_data_tlen;
    logic [TIMER_W-1:0]  r_ack_tlen;
    logic [SEQ_W-1:0]    r_ale;
    logic [SEQ_W-1:0]    r_ns;
    logic [SEQ_W-1:0]    r_exp;
    logic [SEQ_W-1:0]    r_rue;
    logic [SEQ_W-1:0]    r_count;
    logic [WINDOW_SLOTS-1:0] r_marks;
    logic                r_nak_ok;
    logic                r_phys;
    logic                r_ack_start;
    logic [GUARD_W-1:0]  r_guard;
    logic [EMIT_W-1:0]   r_emit_cnt;
    logic                r_strobe;
    t_result             r_result;

    t_result             n_result;
    logic                n_emit;
    logic [SEQ_W-1:0]    to_seq;
    logic [SEQ_W-1:0]    send_seq;
    logic [SEQ_W-1:0]    ack_field;
    logic [SEQ_W-1:0]    nak_seq;
    logic                room;

    // Sequence numbers that a send may use.
    always_comb begin
        nak_seq   = r_item.rx_ack + SEQ_W'(1);
        to_seq    = {~in_window(r_ale, {1'b0, r_item.timeout_slot}, r_ns),
                     r_item.timeout_slot};
        ack_field = r_exp - SEQ_W'(1);
        room      = r_count < SEQ_W'(WINDOW_SLOTS);
        case (r_item.op)
            OP_NET_READY: begin
                send_seq = r_ns;
            end
            OP_FRAME: begin
                send_seq = nak_seq;
            end
            default: begin
                send_seq = to_seq;
            end
        endcase
    end

    // Status toward the controller.
    always_comb begin
        o_stat.op           = r_item.op;
        o_stat.crc_bad      = r_item.crc_bad;
        o_stat.rx_kind      = r_item.rx_kind;
        o_stat.room         = room;
        o_stat.nak_allowed  = r_nak_ok;
        o_stat.seq_mismatch = r_item.rx_seq != r_exp;
        o_stat.store_ok     = in_window(r_exp, r_item.rx_seq, r_rue) &&
                              !r_marks[r_item.rx_seq[SLOT_W-1:0]];
        o_stat.deliver_ok   = r_marks[r_exp[SLOT_W-1:0]] &&
                              (r_guard < GUARD_W'(WINDOW_SLOTS));
        o_stat.stop_ok      = in_window(r_ale, r_item.rx_ack, r_ns) &&
                              (r_guard <= GUARD_W'(MAX_SEQUENCE));
        o_stat.resend_ok    = in_window(r_ale, nak_seq, r_ns);
    end

    // Result item built for the current step.
    always_comb begin
        n_result = '0;
        n_emit   = 1'b1;
        case (i_cmd.step)
            STEP_LOAD: begin
                n_result.action = ACT_LOAD;
                n_result.slot   = r_ns[SLOT_W-1:0];
            end
            STEP_SEND: begin
                n_result.action       = ACT_DATA;
                n_result.tx_seq       = send_seq;
                n_result.tx_ack       = ack_field;
                n_result.slot         = send_seq[SLOT_W-1:0];
                n_result.timer_length = r_data_tlen;
            end
            STEP_NAK: begin
                n_result.action = ACT_NAK;
                n_result.tx_ack = ack_field;
            end
            STEP_SEND_ACK: begin
                n_result.action = ACT_ACK;
                n_result.tx_ack = ack_field;
            end
            STEP_STORE: begin
                n_result.action = ACT_STORE;
                n_result.slot   = r_item.rx_seq[SLOT_W-1:0];
            end
            STEP_DELIVER: begin
                n_result.action = ACT_DELIVER;
                n_result.slot   = r_exp[SLOT_W-1:0];
            end
            STEP_STOP: begin
                n_result.action = ACT_STOP;
                n_result.slot   = r_ale[SLOT_W-1:0];
            end
            STEP_STATUS: begin
                n_result.action         = ACT_STATUS;
                n_result.timer_length   = r_ack_start ? r_ack_tlen : '0;
                n_result.ack_restart    = r_ack_start;
                n_result.network_enable = room && r_phys;
                n_result.last           = 1'b1;
            end
            default: begin
                n_emit = 1'b0;
            end
        endcase
    end

    // Window state, flags and configuration registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_data_tlen <= DATA_TIMER_INIT;
            r_ack_tlen  <= ACK_TIMER_INIT;
            r_ale       <= '0;
            r_ns        <= '0;
            r_exp       <= '0;
            r_rue       <= SEQ_W'(WINDOW_SLOTS);
            r_count     <= '0;
            r_marks     <= '0;
            r_nak_ok    <= 1'b1;
            r_phys      <= 1'b0;
            r_ack_start <= 1'b0;
            r_guard     <= '0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    CFG_DATA_TIMER: begin
                        r_data_tlen <= i_cfg_data;
                    end
                    CFG_ACK_TIMER: begin
                        r_ack_tlen <= i_cfg_data;
                    end
                    default: begin
                    end
                endcase
            end
            if (i_cmd.latch) begin
                r_ack_start <= 1'b0;
                r_guard     <= '0;
            end
            case (i_cmd.step)
                STEP_SEND: begin
                    r_phys <= 1'b0;
                    // A new frame opens a slot and moves the send edge together.
                    if (r_item.op == OP_NET_READY) begin
                        r_count <= r_count + SEQ_W'(1);
                        r_ns    <= r_ns + SEQ_W'(1);
                    end
                end
                STEP_NAK: begin
                    r_nak_ok <= 1'b0;
                end
                STEP_ACK_START: begin
                    r_ack_start <= 1'b1;
                end
                STEP_STORE: begin
                    r_marks[r_item.rx_seq[SLOT_W-1:0]] <= 1'b1;
                end
                STEP_DELIVER: begin
                    r_marks[r_exp[SLOT_W-1:0]] <= 1'b0;
                    r_exp       <= r_exp + SEQ_W'(1);
                    r_rue       <= r_rue + SEQ_W'(1);
                    r_nak_ok    <= 1'b1;
                    r_ack_start <= 1'b1;
                    r_guard     <= r_guard + GUARD_W'(1);
                end
                STEP_STOP: begin
                    if (r_count != '0) begin
                        r_count <= r_count - SEQ_W'(1);
                    end
                    r_ale   <= r_ale + SEQ_W'(1);
                    r_guard <= r_guard + GUARD_W'(1);
                end
                STEP_PHYS: begin
                    r_phys <= 1'b1;
                end
                default: begin
                end
            endcase
        end
    end

    // Captured event item.
    always_ff @(posedge i_clk) begin
        if (i_cmd.latch) begin
            r_item <= i_item;
        end
    end

    // Result port; commands past the per-event limit are dropped, status never.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_strobe   <= 1'b0;
            r_emit_cnt <= '0;
        end else begin
            r_strobe <= 1'b0;
            if (i_cmd.latch) begin
                r_emit_cnt <= '0;
            end
            if (n_emit) begin
                if (n_result.last) begin
                    r_strobe <= 1'b1;
                end else if (r_emit_cnt < EMIT_W'(MAX_RESULTS - 1)) begin
                    r_strobe   <= 1'b1;
                    r_emit_cnt <= r_emit_cnt + EMIT_W'(1);
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (n_emit) begin
            r_result <= n_result;
        end
    end

    assign o_strobe = r_strobe;
    assign o_result = r_result;

    // The outstanding count never exceeds the window.
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= SEQ_W'(WINDOW_SLOTS))
        else $error("outstanding count above window");

    // The outstanding count equals the span of the send window.
    a_count_span: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count == SEQ_W'(r_ns - r_ale))
        else $error("outstanding count disagrees with send window");

    // The receive window always spans exactly the window size.
    a_rx_span: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        SEQ_W'(r_rue - r_exp) == SEQ_W'(WINDOW_SLOTS))
        else $error("receive window edges out of step");

    // A status item is followed by a quiet cycle.
    a_status_gap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_strobe && r_result.last) |=> !r_strobe)
        else $error("result directly after status item");

endmodule

/* hw/rtl/srarq_ctrl.sv */
// ----------------------------------------------------------------------------
// srarq_ctrl
// Sequencer of the ARQ controller: decodes the captured event and walks the
// datapath through its commands, at most one step per cycle, ending with status.
// ----------------------------------------------------------------------------
module srarq_ctrl import srarq_pkg::*; (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_accept,
    input  t_dp_stat i_stat,
    output t_dp_cmd  o_cmd,
    output logic     o_busy
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_DECODE,
        S_SEND,
        S_STORE,
        S_DELIVER,
        S_STOP,
        S_STATUS
    } t_state;

    t_state r_state;
    t_state n_state;

    // Next state and datapath step.
    always_comb begin
        n_state     = r_state;
        o_cmd.latch = 1'b0;
        o_cmd.step  = STEP_NONE;
        case (r_state)
            S_IDLE: begin
                if (i_accept) begin
                    o_cmd.latch = 1'b1;
                    n_state     = S_DECODE;
                end
            end
            S_DECODE: begin
                n_state = S_STATUS;
                case (i_stat.op)
                    OP_NET_READY: begin
                        if (i_stat.room) begin
                            o_cmd.step = STEP_LOAD;
                            n_state    = S_SEND;
                        end
                    end
                    OP_PHYS_READY: begin
                        o_cmd.step = STEP_PHYS;
                    end
                    OP_FRAME: begin
                        if (i_stat.crc_bad) begin
                            if (i_stat.nak_allowed) begin
                                o_cmd.step = STEP_NAK;
                            end
                        end else begin
                            case (i_stat.rx_kind)
                                KIND_DATA: begin
                                    if (i_stat.seq_mismatch && i_stat.nak_allowed) begin
                                        o_cmd.step = STEP_NAK;
                                    end else begin
                                        o_cmd.step = STEP_ACK_START;
                                    end
                                    n_state = S_STORE;
                                end
                                KIND_ACK: begin
                                    n_state = S_STOP;
                                end
                                KIND_NAK: begin
                                    if (i_stat.resend_ok) begin
                                        o_cmd.step = STEP_SEND;
                                    end
                                end
                                default: begin
                                end
                            endcase
                        end
                    end
                    OP_DATA_TMO: begin
                        o_cmd.step = STEP_SEND;
                    end
                    OP_ACK_TMO: begin
                        o_cmd.step = STEP_SEND_ACK;
                    end
                    default: begin
                    end
                endcase
            end
            S_SEND: begin
                o_cmd.step = STEP_SEND;
                n_state    = S_STATUS;
            end
            S_STORE: begin
                if (i_stat.store_ok) begin
                    o_cmd.step = STEP_STORE;
                    n_state    = S_DELIVER;
                end else begin
                    n_state = S_STATUS;
                end
            end
            S_DELIVER: begin
                if (i_stat.deliver_ok) begin
                    o_cmd.step = STEP_DELIVER;
                end else begin
                    n_state = S_STATUS;
                end
            end
            S_STOP: begin
                if (i_stat.stop_ok) begin
                    o_cmd.step = STEP_STOP;
                end else begin
                    n_state = S_STATUS;
                end
            end
            S_STATUS: begin
                o_cmd.step = STEP_STATUS;
                n_state    = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // State register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_busy = r_state != S_IDLE;

endmodule

/* hw/rtl/selective_repeat_arq_controller.sv */
// ----------------------------------------------------------------------------
// selective_repeat_arq_controller
// The item is captured at the accepting edge and decoded; the sequencer then
// issues any load, send, store, deliver or stop steps and ends with status,
// which reaches the result port through its output register. No new item is
// taken until status is issued; a data frame that delivers eight slots is
// the longest walk, and the receiver cannot stall the results.
// Synchronous active-low reset clears window state and marks.
// ----------------------------------------------------------------------------
module selective_repeat_arq_controller import srarq_pkg::*; (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 start,
    output logic                 busy,
    input  t_item                i_item,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [TIMER_W-1:0]   i_cfg_data,
    output logic                 o_strobe,
    output t_result              o_result
);

    t_dp_cmd  cmd;
    t_dp_stat stat;
    logic     accept;

    // An item is taken only while the sequencer is idle.
    assign accept = start && !busy;

    srarq_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_accept (accept),
        .i_stat   (stat),
        .o_cmd    (cmd),
        .o_busy   (busy)
    );

    srarq_dp u_dp (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_item     (i_item),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_cmd      (cmd),
        .o_stat     (stat),
        .o_strobe   (o_strobe),
        .o_result   (o_result)
    );

endmodule
